// ===== sv/lcabl_pkg.sv =====
// ----------------------------------------------------------------------------
// lcabl_pkg: shared types and constants for the binary-lifting LCA block
// Payload structs, memory control structs, action and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lcabl_pkg;

   localparam int NODE_W     = 10;
   localparam int NODES      = 1024;
   localparam int LEVELS     = 11;
   localparam int LVL_W      = 4;
   localparam int EDGE_SLOTS = 2 * NODES;
   localparam int ECNT_W     = 12;
   localparam int EIDX_W     = 11;
   localparam int DEPTH_W    = 11;
   localparam int ANC_ADDR_W = LVL_W + NODE_W;
   localparam int ANC_DEPTH  = LEVELS * NODES;
   localparam int TOP_W      = 11;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_BUILD = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]        action;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic [1:0]        status;
   } rsp_type;

   // edge store control and read data
   typedef struct packed {
      logic [NODE_W-1:0] head_raddr;
      logic              head_we;
      logic [NODE_W-1:0] head_waddr;
      logic [ECNT_W-1:0] head_wdata;
      logic [EIDX_W-1:0] edge_raddr;
      logic              edge_we;
      logic [EIDX_W-1:0] edge_waddr;
      logic [ECNT_W-1:0] next_wdata;
      logic [NODE_W-1:0] target_wdata;
   } edge_ctl_type;

   typedef struct packed {
      logic [ECNT_W-1:0] head_rd;
      logic [ECNT_W-1:0] next_rd;
      logic [NODE_W-1:0] target_rd;
   } edge_dat_type;

   // depth, ancestor and walk stack control and read data
   typedef struct packed {
      logic [NODE_W-1:0]     depth_raddr;
      logic                  depth_we;
      logic [NODE_W-1:0]     depth_waddr;
      logic [DEPTH_W-1:0]    depth_wdata;
      logic [ANC_ADDR_W-1:0] anc_raddr;
      logic                  anc_we;
      logic [ANC_ADDR_W-1:0] anc_waddr;
      logic [NODE_W-1:0]     anc_wdata;
      logic [NODE_W-1:0]     stk_raddr;
      logic                  stk_we;
      logic [NODE_W-1:0]     stk_waddr;
      logic [NODE_W-1:0]     stk_wdata;
   } tbl_ctl_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth_rd;
      logic [NODE_W-1:0]  anc_rd;
      logic [NODE_W-1:0]  stk_rd;
   } tbl_dat_type;

   function automatic logic node_ok(input logic [NODE_W-1:0] n,
                                    input logic [NODE_W-1:0] cnt);
      return (n != '0) && (n <= cnt);
   endfunction

endpackage

`default_nettype wire

// ===== sv/lcabl_edges.sv =====
// ----------------------------------------------------------------------------
// lcabl_edges: adjacency list store
// List heads per node, next links and targets per entry; registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module lcabl_edges (
   input  wire logic                   clock,
   input  wire lcabl_pkg::edge_ctl_type ctl,
   output lcabl_pkg::edge_dat_type      dat
);
   import lcabl_pkg::*;

   logic [ECNT_W-1:0] head_mem   [0:NODES-1];
   logic [ECNT_W-1:0] next_mem   [0:EDGE_SLOTS-1];
   logic [NODE_W-1:0] target_mem [0:EDGE_SLOTS-1];

   // list heads, entry links and targets
   always_ff @(posedge clock) begin
      if (ctl.head_we) begin
         head_mem[ctl.head_waddr] <= ctl.head_wdata;
      end
      if (ctl.edge_we) begin
         next_mem[ctl.edge_waddr]   <= ctl.next_wdata;
         target_mem[ctl.edge_waddr] <= ctl.target_wdata;
      end
      dat.head_rd   <= head_mem[ctl.head_raddr];
      dat.next_rd   <= next_mem[ctl.edge_raddr];
      dat.target_rd <= target_mem[ctl.edge_raddr];
   end

endmodule

`default_nettype wire

// ===== sv/lcabl_tables.sv =====
// ----------------------------------------------------------------------------
// lcabl_tables: depth table, ancestor table and walk stack
// Ancestor entries are addressed by {level, node}; all reads registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lcabl_tables (
   input  wire logic                  clock,
   input  wire lcabl_pkg::tbl_ctl_type ctl,
   output lcabl_pkg::tbl_dat_type      dat
);
   import lcabl_pkg::*;

   logic [DEPTH_W-1:0] depth_mem [0:NODES-1];
   logic [NODE_W-1:0]  anc_mem   [0:ANC_DEPTH-1];
   logic [NODE_W-1:0]  stk_mem   [0:NODES-1];

   // node depths, ancestor table and walk stack
   always_ff @(posedge clock) begin
      if (ctl.depth_we) begin
         depth_mem[ctl.depth_waddr] <= ctl.depth_wdata;
      end
      if (ctl.anc_we) begin
         anc_mem[ctl.anc_waddr] <= ctl.anc_wdata;
      end
      if (ctl.stk_we) begin
         stk_mem[ctl.stk_waddr] <= ctl.stk_wdata;
      end
      dat.depth_rd <= depth_mem[ctl.depth_raddr];
      dat.anc_rd   <= anc_mem[ctl.anc_raddr];
      dat.stk_rd   <= stk_mem[ctl.stk_raddr];
   end

endmodule

`default_nettype wire

// ===== sv/lca_binary_lifting_top.sv =====
// ----------------------------------------------------------------------------
// lca_binary_lifting_top: lowest common ancestor by binary lifting
// Edge store, tree walk, ancestor table fill and lifting queries under one
// sequencer that issues one memory access per table per cycle.
// ----------------------------------------------------------------------------
//  channel  ports                         direction
//  request  req_valid req_stall req_data  in  (action, node_a, node_b)
//  result   rsp_valid rsp_stall rsp_data  out (ancestor, status)
//  config   csr_wr_en csr_wr_data         in  (node_count)
//
//  An add writes two list entries; a query makes two table reads per
//  level in two passes over eleven levels; a build clears the depth and
//  ancestor tables, walks the tree from node 1 over each edge entry and
//  popped node, then fills the ancestor table over ten levels.
//  After reset a clearing pass over all 11264 ancestor entries runs first.
//  One item at a time; a finished result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_binary_lifting_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire lcabl_pkg::req_type           req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output lcabl_pkg::rsp_type                rsp_data,
   input  wire logic                         csr_wr_en,
   input  wire logic [lcabl_pkg::NODE_W-1:0] csr_wr_data
);
   import lcabl_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_ADD_RA, S_ADD_WA, S_ADD_RB, S_ADD_WB,
      S_B_START, S_POP, S_POP_W, S_U_GET, S_EDGE, S_E_RD, S_E_CHK,
      S_L_RD, S_L_RD2, S_L_WR,
      S_Q_DA, S_Q_DB, S_Q_ORD, S_Q_UPA, S_Q_UPB, S_Q_UPC, S_Q_EQ,
      S_Q_BA, S_Q_BB, S_Q_BC, S_Q_PA, S_Q_PB,
      S_DONE
   } state_type;

   localparam logic [LVL_W-1:0]      LAST_LVL = LVL_W'(LEVELS - 1);
   localparam logic [ANC_ADDR_W-1:0] CLR_LAST = ANC_ADDR_W'(ANC_DEPTH - 1);

   state_type             state_ff, state_in;
   logic [ANC_ADDR_W-1:0] clr_ff, clr_in;
   logic                  clr_adj_ff, clr_adj_in;
   logic [NODE_W-1:0]     ncnt_ff, ncnt_in;
   logic [ECNT_W-1:0]     ec_ff, ec_in;
   logic [NODE_W-1:0]     a_ff, a_in, b_ff, b_in;
   logic [DEPTH_W-1:0]    dy_ff, dy_in, du_ff, du_in;
   logic [TOP_W-1:0]      top_ff, top_in;
   logic [NODE_W-1:0]     u_ff, u_in, t_ff, t_in, ax_ff, ax_in, v_ff, v_in;
   logic [ECNT_W-1:0]     e_ff, e_in;
   logic [LVL_W-1:0]      lvl_ff, lvl_in, idx_ff, idx_in;
   logic [NODE_W-1:0]     res_anc_ff, res_anc_in;
   logic [1:0]            res_st_ff, res_st_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   edge_ctl_type ectl;
   edge_dat_type edat;
   tbl_ctl_type  tctl;
   tbl_dat_type  tdat;

   lcabl_edges u_edges (.clock(clock), .ctl(ectl), .dat(edat));
   lcabl_tables u_tables (.clock(clock), .ctl(tctl), .dat(tdat));

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequence all actions
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_adj_in   = clr_adj_ff;
      ncnt_in      = ncnt_ff;
      ec_in        = ec_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      dy_in        = dy_ff;
      du_in        = du_ff;
      top_in       = top_ff;
      u_in         = u_ff;
      t_in         = t_ff;
      ax_in        = ax_ff;
      v_in         = v_ff;
      e_in         = e_ff;
      lvl_in       = lvl_ff;
      idx_in       = idx_ff;
      res_anc_in   = res_anc_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ectl         = '0;
      tctl         = '0;

      // drop the result once transferred
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr_en) begin
         ncnt_in = csr_wr_data;
      end

      unique case (state_ff)
         S_CLEAR: begin
            tctl.anc_we    = 1'b1;
            tctl.anc_waddr = clr_ff;
            if (clr_ff[ANC_ADDR_W-1:NODE_W] == '0) begin
               tctl.depth_we    = 1'b1;
               tctl.depth_waddr = clr_ff[NODE_W-1:0];
               ectl.head_we     = clr_adj_ff;
               ectl.head_waddr  = clr_ff[NODE_W-1:0];
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = clr_adj_ff ? S_IDLE : S_B_START;
            end
         end
         S_IDLE: begin
            res_anc_in = '0;
            res_st_in  = ST_OK;
            if (req_valid) begin
               a_in = req_data.node_a;
               b_in = req_data.node_b;
               case (req_data.action)
                  ACT_ADD: begin
                     if (!node_ok(req_data.node_a, ncnt_ff) ||
                         !node_ok(req_data.node_b, ncnt_ff)) begin
                        res_st_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else if (ec_ff > ECNT_W'(EDGE_SLOTS - 2)) begin
                        res_st_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_ADD_RA;
                     end
                  end
                  ACT_BUILD: begin
                     clr_in     = '0;
                     clr_adj_in = 1'b0;
                     state_in   = S_CLEAR;
                  end
                  ACT_QUERY: begin
                     if (!node_ok(req_data.node_a, ncnt_ff) ||
                         !node_ok(req_data.node_b, ncnt_ff)) begin
                        res_st_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_Q_DA;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         // link entry a -> b, then b -> a
         S_ADD_RA: begin
            ectl.head_raddr = a_ff;
            state_in        = S_ADD_WA;
         end
         S_ADD_WA: begin
            ectl.edge_we      = 1'b1;
            ectl.edge_waddr   = ec_ff[EIDX_W-1:0];
            ectl.target_wdata = b_ff;
            ectl.next_wdata   = edat.head_rd;
            ectl.head_we      = 1'b1;
            ectl.head_waddr   = a_ff;
            ectl.head_wdata   = ec_ff + 1'b1;
            ec_in             = ec_ff + 1'b1;
            state_in          = S_ADD_RB;
         end
         S_ADD_RB: begin
            ectl.head_raddr = b_ff;
            state_in        = S_ADD_WB;
         end
         S_ADD_WB: begin
            ectl.edge_we      = 1'b1;
            ectl.edge_waddr   = ec_ff[EIDX_W-1:0];
            ectl.target_wdata = a_ff;
            ectl.next_wdata   = edat.head_rd;
            ectl.head_we      = 1'b1;
            ectl.head_waddr   = b_ff;
            ectl.head_wdata   = ec_ff + 1'b1;
            ec_in             = ec_ff + 1'b1;
            state_in          = S_DONE;
         end
         // seed the walk with node 1
         S_B_START: begin
            if (ncnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               tctl.depth_we    = 1'b1;
               tctl.depth_waddr = NODE_W'(1);
               tctl.depth_wdata = DEPTH_W'(1);
               tctl.stk_we      = 1'b1;
               tctl.stk_waddr   = '0;
               tctl.stk_wdata   = NODE_W'(1);
               top_in           = TOP_W'(1);
               state_in         = S_POP;
            end
         end
         S_POP: begin
            if (top_ff == '0) begin
               lvl_in   = LVL_W'(1);
               v_in     = NODE_W'(1);
               state_in = S_L_RD;
            end else begin
               top_in         = top_ff - 1'b1;
               tctl.stk_raddr = NODE_W'(top_ff - 1'b1);
               state_in       = S_POP_W;
            end
         end
         S_POP_W: begin
            u_in             = tdat.stk_rd;
            ectl.head_raddr  = tdat.stk_rd;
            tctl.depth_raddr = tdat.stk_rd;
            state_in         = S_U_GET;
         end
         S_U_GET: begin
            e_in     = edat.head_rd;
            du_in    = tdat.depth_rd;
            state_in = S_EDGE;
         end
         S_EDGE: begin
            if (e_ff == '0 || e_ff > ECNT_W'(EDGE_SLOTS)) begin
               state_in = S_POP;
            end else begin
               ectl.edge_raddr = EIDX_W'(e_ff - 1'b1);
               state_in        = S_E_RD;
            end
         end
         S_E_RD: begin
            t_in             = edat.target_rd;
            e_in             = edat.next_rd;
            tctl.depth_raddr = edat.target_rd;
            state_in         = S_E_CHK;
         end
         // visit an unreached valid neighbor
         S_E_CHK: begin
            if (node_ok(t_ff, ncnt_ff) && tdat.depth_rd == '0 &&
                top_ff < TOP_W'(NODES)) begin
               tctl.depth_we    = 1'b1;
               tctl.depth_waddr = t_ff;
               tctl.depth_wdata = du_ff + 1'b1;
               tctl.anc_we      = 1'b1;
               tctl.anc_waddr   = {LVL_W'(0), t_ff};
               tctl.anc_wdata   = u_ff;
               tctl.stk_we      = 1'b1;
               tctl.stk_waddr   = top_ff[NODE_W-1:0];
               tctl.stk_wdata   = t_ff;
               top_in           = top_ff + 1'b1;
            end
            state_in = S_EDGE;
         end
         // ancestor(v, k) = ancestor(ancestor(v, k-1), k-1)
         S_L_RD: begin
            tctl.anc_raddr = {lvl_ff - 1'b1, v_ff};
            state_in       = S_L_RD2;
         end
         S_L_RD2: begin
            tctl.anc_raddr = {lvl_ff - 1'b1, tdat.anc_rd};
            state_in       = S_L_WR;
         end
         S_L_WR: begin
            tctl.anc_we    = 1'b1;
            tctl.anc_waddr = {lvl_ff, v_ff};
            tctl.anc_wdata = tdat.anc_rd;
            state_in       = S_L_RD;
            if (v_ff == ncnt_ff) begin
               v_in = NODE_W'(1);
               if (lvl_ff == LAST_LVL) begin
                  state_in = S_DONE;
               end else begin
                  lvl_in = lvl_ff + 1'b1;
               end
            end else begin
               v_in = v_ff + 1'b1;
            end
         end
         // order the query nodes by depth
         S_Q_DA: begin
            tctl.depth_raddr = a_ff;
            state_in         = S_Q_DB;
         end
         S_Q_DB: begin
            dy_in            = tdat.depth_rd;
            tctl.depth_raddr = b_ff;
            state_in         = S_Q_ORD;
         end
         S_Q_ORD: begin
            if (dy_ff < tdat.depth_rd) begin
               a_in = b_ff;
               b_in = a_ff;
            end else begin
               dy_in = tdat.depth_rd;
            end
            idx_in   = LAST_LVL;
            state_in = S_Q_UPA;
         end
         // lift the deeper node
         S_Q_UPA: begin
            tctl.anc_raddr = {idx_ff, a_ff};
            state_in       = S_Q_UPB;
         end
         S_Q_UPB: begin
            t_in             = tdat.anc_rd;
            tctl.depth_raddr = tdat.anc_rd;
            state_in         = S_Q_UPC;
         end
         S_Q_UPC: begin
            if (tdat.depth_rd >= dy_ff) begin
               a_in = t_ff;
            end
            if (idx_ff == '0) begin
               state_in = S_Q_EQ;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = S_Q_UPA;
            end
         end
         S_Q_EQ: begin
            if (a_ff == b_ff) begin
               res_anc_in = a_ff;
               state_in   = S_DONE;
            end else begin
               idx_in   = LAST_LVL;
               state_in = S_Q_BA;
            end
         end
         // lift both while their ancestors differ
         S_Q_BA: begin
            tctl.anc_raddr = {idx_ff, a_ff};
            state_in       = S_Q_BB;
         end
         S_Q_BB: begin
            ax_in          = tdat.anc_rd;
            tctl.anc_raddr = {idx_ff, b_ff};
            state_in       = S_Q_BC;
         end
         S_Q_BC: begin
            if (ax_ff != tdat.anc_rd) begin
               a_in = ax_ff;
               b_in = tdat.anc_rd;
            end
            if (idx_ff == '0) begin
               state_in = S_Q_PA;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = S_Q_BA;
            end
         end
         S_Q_PA: begin
            tctl.anc_raddr = {LVL_W'(0), a_ff};
            state_in       = S_Q_PB;
         end
         S_Q_PB: begin
            res_anc_in = tdat.anc_rd;
            state_in   = S_DONE;
         end
         // hold the result until the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_in.ancestor = res_anc_ff;
               rsp_in.status   = res_st_ff;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         clr_adj_ff   <= 1'b1;
         ncnt_ff      <= NODE_W'(1);
         ec_ff        <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_adj_ff   <= clr_adj_in;
         ncnt_ff      <= ncnt_in;
         ec_ff        <= ec_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      dy_ff      <= dy_in;
      du_ff      <= du_in;
      u_ff       <= u_in;
      t_ff       <= t_in;
      ax_ff      <= ax_in;
      v_ff       <= v_in;
      e_ff       <= e_in;
      lvl_ff     <= lvl_in;
      idx_ff     <= idx_in;
      res_anc_ff <= res_anc_in;
      res_st_ff  <= res_st_in;
      rsp_ff     <= rsp_in;
   end

endmodule

`default_nettype wire
